/* rtl/gse_pkg.sv */
// shared types, constants and lookup functions for the 6-and-2 gcr sector encoder
// no dependencies; used by gse_ctrl, gse_datapath and the top level
`default_nettype none

package gse_pkg;

	// request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_PULL  = 2'd2;

	localparam int unsigned SEC_BYTES = 256;
	localparam int unsigned AUX_LEN   = 86;
	localparam int unsigned AUX_AW    = 7;
	localparam int unsigned PRI_AW    = 8;

	// nibble positions inside one sector image
	localparam logic [8:0] POS_DATA_START = 9'd28;
	localparam logic [8:0] POS_PRIMARY    = 9'd114;
	localparam logic [8:0] POS_LANE2_END  = 9'd112;
	localparam logic [8:0] POS_CSUM       = 9'd370;
	localparam logic [8:0] POS_EPI_AA     = 9'd372;
	localparam logic [8:0] POS_FINAL      = 9'd373;

	localparam logic [6:0] AUX_LAST_IDX = 7'd85;
	localparam logic [7:0] VOLUME_RESET = 8'd254;
	localparam logic [7:0] NIB_SYNC     = 8'hff;

	localparam logic [7:0] GCR_TABLE [64] = '{
		8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
		8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
		8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
		8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
		8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
		8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
		8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
		8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
	};

	// controller to datapath commands
	typedef struct packed {
		logic start;   // latch track/sector, restart load and emission
		logic load;    // store one data byte
		logic rd;      // launch store read for the pending pull
		logic commit;  // write result register and advance emission
	} gse_cmd_t;

	// 4-and-4: odd bits first, then even bits, each padded with ones
	function automatic logic [7:0] enc44(input logic [7:0] v, input logic second);
		logic [7:0] x;
		begin
			x = second ? v : {1'b0, v[7:1]};
			return (x & 8'h55) | 8'haa;
		end
	endfunction

	// gaps, prologs, epilog and address field for positions below the data field
	function automatic logic [7:0] header_nibble(input logic [4:0] pos, input logic [7:0] vol,
			input logic [7:0] trk, input logic [7:0] sec);
		logic [7:0] csum;
		logic [7:0] r;
		begin
			csum = vol ^ trk ^ sec;
			case (pos) inside
				[5'd0:5'd5]:   r = NIB_SYNC;
				5'd6:          r = 8'hd5;
				5'd7:          r = 8'haa;
				5'd8:          r = 8'h96;
				[5'd9:5'd10]:  r = enc44(vol, pos == 5'd10);
				[5'd11:5'd12]: r = enc44(trk, pos == 5'd12);
				[5'd13:5'd14]: r = enc44(sec, pos == 5'd14);
				[5'd15:5'd16]: r = enc44(csum, pos == 5'd16);
				5'd17:         r = 8'hde;
				5'd18:         r = 8'haa;
				5'd19:         r = 8'heb;
				[5'd20:5'd24]: r = NIB_SYNC;
				5'd25:         r = 8'hd5;
				5'd26:         r = 8'haa;
				5'd27:         r = 8'had;
				default:       r = NIB_SYNC;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/gse_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module gse_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/gse_ctrl.sv */
// controller: input/output handshakes and pull sequencing
// depends on gse_pkg
`default_nettype none

module gse_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [1:0]        req_type,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      gse_pkg::gse_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic in_acc;
	logic slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.start  = in_acc && (req_type == gse_pkg::REQ_START);
		cmd.load   = in_acc && (req_type == gse_pkg::REQ_LOAD);
		cmd.rd     = in_acc && (req_type == gse_pkg::REQ_PULL);
		cmd.commit = (state_q == ST_READ) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.rd) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// hold here until the result register can take the nibble
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/gse_datapath.sv */
// datapath: sector stores, load counters, nibble generation and result register
// depends on gse_pkg and gse_ram
`default_nettype none

module gse_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gse_pkg::gse_cmd_t cmd,
	input  wire logic [7:0]        data_byte,
	input  wire logic [7:0]        track_num,
	input  wire logic [7:0]        sector_num,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_data,
	output      logic [7:0]        nibble,
	output      logic              last,
	output      logic              underrun
);

	logic [7:0] volume_q;
	logic [7:0] track_q;
	logic [7:0] sector_q;
	logic [8:0] load_cnt_q;
	logic [6:0] aux_idx_q;
	logic [1:0] lane_q;
	logic       ready_q;
	logic [8:0] emit_pos_q;
	logic [5:0] prev_q;
	logic [7:0] nibble_q;
	logic       last_q;
	logic       underrun_q;

	logic       load_ok;
	logic [1:0] pair;
	logic [5:0] pri_rdata;
	logic [1:0] lane_rdata [3];
	logic [8:0] aux_off;
	logic [8:0] pri_off;
	logic [5:0] cur;
	logic [7:0] nib_d;
	logic       chain;
	logic       lane2_we;
	logic       lane1_we;
	logic       lane0_we;

	assign load_ok  = cmd.load && !load_cnt_q[8];
	assign pair     = {data_byte[0], data_byte[1]};
	assign lane0_we = load_ok && (lane_q == 2'd0);
	assign lane1_we = load_ok && (lane_q == 2'd1);
	assign lane2_we = load_ok && (lane_q == 2'd2);
	assign aux_off  = emit_pos_q - gse_pkg::POS_DATA_START;
	assign pri_off  = emit_pos_q - gse_pkg::POS_PRIMARY;

	gse_ram #(.WIDTH(6), .DEPTH(gse_pkg::SEC_BYTES)) u_primary (
		.clk   (clk),
		.we    (load_ok),
		.waddr (load_cnt_q[gse_pkg::PRI_AW-1:0]),
		.wdata (data_byte[7:2]),
		.re    (cmd.rd),
		.raddr (pri_off[gse_pkg::PRI_AW-1:0]),
		.rdata (pri_rdata)
	);

	// secondary store split in three 2-bit lanes so every entry is written once
	gse_ram #(.WIDTH(2), .DEPTH(gse_pkg::AUX_LEN)) u_lane0 (
		.clk   (clk),
		.we    (lane0_we),
		.waddr (aux_idx_q),
		.wdata (pair),
		.re    (cmd.rd),
		.raddr (aux_off[gse_pkg::AUX_AW-1:0]),
		.rdata (lane_rdata[0])
	);

	gse_ram #(.WIDTH(2), .DEPTH(gse_pkg::AUX_LEN)) u_lane1 (
		.clk   (clk),
		.we    (lane1_we),
		.waddr (aux_idx_q),
		.wdata (pair),
		.re    (cmd.rd),
		.raddr (aux_off[gse_pkg::AUX_AW-1:0]),
		.rdata (lane_rdata[1])
	);

	gse_ram #(.WIDTH(2), .DEPTH(gse_pkg::AUX_LEN)) u_lane2 (
		.clk   (clk),
		.we    (lane2_we),
		.waddr (aux_idx_q),
		.wdata (pair),
		.re    (cmd.rd),
		.raddr (aux_off[gse_pkg::AUX_AW-1:0]),
		.rdata (lane_rdata[2])
	);

	always_comb begin
		chain = 1'b0;
		cur   = 6'd0;
		if (emit_pos_q < gse_pkg::POS_PRIMARY) begin
			// last two secondary entries only ever get two pairs
			cur = {(emit_pos_q >= gse_pkg::POS_LANE2_END) ? 2'b00 : lane_rdata[2],
				lane_rdata[1], lane_rdata[0]};
		end else if (emit_pos_q < gse_pkg::POS_CSUM) begin
			cur = pri_rdata;
		end
		if (!ready_q) begin
			nib_d = gse_pkg::NIB_SYNC;
		end else if (emit_pos_q < gse_pkg::POS_DATA_START) begin
			nib_d = gse_pkg::header_nibble(emit_pos_q[4:0], volume_q, track_q, sector_q);
		end else if (emit_pos_q <= gse_pkg::POS_CSUM) begin
			chain = 1'b1;
			nib_d = gse_pkg::GCR_TABLE[cur ^ prev_q];
		end else if (emit_pos_q < gse_pkg::POS_EPI_AA) begin
			nib_d = 8'hde;
		end else if (emit_pos_q == gse_pkg::POS_EPI_AA) begin
			nib_d = 8'haa;
		end else begin
			nib_d = 8'heb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q   <= gse_pkg::VOLUME_RESET;
			track_q    <= 8'd0;
			sector_q   <= 8'd0;
			load_cnt_q <= 9'd0;
			aux_idx_q  <= 7'd0;
			lane_q     <= 2'd0;
			ready_q    <= 1'b0;
			emit_pos_q <= 9'd0;
			prev_q     <= 6'd0;
		end else begin
			if (cfg_we) begin
				volume_q <= cfg_data;
			end
			if (cmd.start) begin
				track_q    <= track_num;
				sector_q   <= sector_num;
				load_cnt_q <= 9'd0;
				aux_idx_q  <= 7'd0;
				lane_q     <= 2'd0;
				ready_q    <= 1'b0;
				emit_pos_q <= 9'd0;
				prev_q     <= 6'd0;
			end
			if (load_ok) begin
				load_cnt_q <= load_cnt_q + 9'd1;
				if (aux_idx_q == gse_pkg::AUX_LAST_IDX) begin
					aux_idx_q <= 7'd0;
					lane_q    <= lane_q + 2'd1;
				end else begin
					aux_idx_q <= aux_idx_q + 7'd1;
				end
				if (load_cnt_q[7:0] == 8'hff) begin
					ready_q <= 1'b1;
				end
			end
			if (cmd.commit && ready_q) begin
				if (emit_pos_q >= gse_pkg::POS_FINAL) begin
					emit_pos_q <= 9'd0;
					prev_q     <= 6'd0;
					ready_q    <= 1'b0;
				end else begin
					emit_pos_q <= emit_pos_q + 9'd1;
					if (chain) begin
						prev_q <= cur;
					end
				end
			end
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			nibble_q   <= nib_d;
			last_q     <= ready_q && (emit_pos_q >= gse_pkg::POS_FINAL);
			underrun_q <= !ready_q;
		end
	end

	assign nibble   = nibble_q;
	assign last     = last_q;
	assign underrun = underrun_q;

endmodule

`default_nettype wire

/* rtl/gcr_6and2_sector_encoder_unit.sv */
// 6-and-2 gcr sector encoder: usage
// input channel (in_valid/in_ready) carries req_type, data_byte, track_num and
// sector_num. a start transaction latches track and sector and restarts loading;
// the next 256 load transactions deliver the sector bytes, later ones are dropped.
// each pull transaction returns one result on the output channel (out_valid/
// out_ready): the next of 374 disk nibbles, with last high on the final epilog
// byte, or 0xff with underrun high when no full sector is loaded or the loaded
// one is already fully emitted. start and load transactions give no result; a
// new item can follow in the next cycle. a pull first does the synchronous store
// read, then the xor chain and translation into the result register, which sets
// out_valid; in_ready stays low from the pull until its result is written. while
// a result waits for out_ready, start and load transactions are still taken; a
// further pull holds in_ready low until the result register frees up. the config
// channel (cfg_valid/cfg_ready/cfg_data) writes the volume number at any cycle.
// reset sets the volume to 254 with no sector loaded; the stores need no clearing
// pass.
// depends on gse_pkg, gse_ctrl, gse_datapath and gse_ram
`default_nettype none

module gcr_6and2_sector_encoder_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] track_num,
	input  wire logic [7:0] sector_num,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] nibble,
	output      logic       last,
	output      logic       underrun,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [7:0] cfg_data
);

	gse_pkg::gse_cmd_t cmd;

	assign cfg_ready = 1'b1;

	gse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	gse_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.track_num  (track_num),
		.sector_num (sector_num),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.nibble     (nibble),
		.last       (last),
		.underrun   (underrun)
	);

endmodule

`default_nettype wire
